// ===== hdl/led_mode_blink_breath_controller_macros.svh =====
// ----------------------------------------------------------------------------
// LED mode controller assertion macros
// Shared wrappers for the concurrent checks on the controller ports.
// ----------------------------------------------------------------------------
`ifndef LED_MODE_BLINK_BREATH_CONTROLLER_MACROS_SVH
`define LED_MODE_BLINK_BREATH_CONTROLLER_MACROS_SVH

// check that is skipped while reset is held
`define LMBB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// check that also covers the reset cycles
`define LMBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lmbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbb_pkg
// Shared types, codes and reset values of the LED mode controller.
// ----------------------------------------------------------------------------
package lmbb_pkg;

    localparam int NUM_LEDS_DEF = 6;
    localparam int LAMP_W       = 6;
    localparam int DUTY_W       = 16;
    localparam int PERIOD_W     = 16;
    localparam int IDX_W        = 3;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 3;

    // led modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEDIUM = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAST   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TWICE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BREATH = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd4;

    localparam logic [PERIOD_W-1:0] FAST_RST   = 16'd20;
    localparam logic [PERIOD_W-1:0] MEDIUM_RST = 16'd50;
    localparam logic [PERIOD_W-1:0] SLOW_RST   = 16'd100;
    localparam logic [DUTY_W-1:0]   STEP_RST   = 16'd10;
    localparam logic [DUTY_W-1:0]   MAX_RST    = 16'd1000;

    // gap below the duty ceiling where rising turns to falling
    localparam logic [DUTY_W:0] BREATH_MARGIN = 17'd100;
    localparam logic [1:0]      TWICE_COUNT   = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SET,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [MODE_W-1:0] new_mode;
    } t_entry;

    typedef struct packed {
        logic [PERIOD_W-1:0] fast;
        logic [PERIOD_W-1:0] mid;
        logic [PERIOD_W-1:0] slow;
        logic [DUTY_W-1:0]   step;
        logic [DUTY_W-1:0]   max;
    } t_cfg;

endpackage

// ===== hdl/lmbb_front.sv =====
// ----------------------------------------------------------------------------
// lmbb_front
// Accepts commands and sorts them into tick, set or skipped set entries.
// ----------------------------------------------------------------------------
module lmbb_front #(
    parameter int NUM_LEDS = lmbb_pkg::NUM_LEDS_DEF
) (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [lmbb_pkg::IDX_W-1:0]    i_led_index,
    input  logic [lmbb_pkg::MODE_W-1:0]   i_new_mode,
    input  logic                          i_full,
    output logic                          o_push,
    output lmbb_pkg::t_entry              o_entry
);

    logic in_range;

    assign in_range   = 32'(i_led_index) < NUM_LEDS;
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_entry.idx      = i_led_index;
        o_entry.new_mode = i_new_mode;
        if (!i_command) begin
            o_entry.kind = lmbb_pkg::KIND_TICK;
        end else if (in_range) begin
            o_entry.kind = lmbb_pkg::KIND_SET;
        end else begin
            // set aimed past the last led: answered without a change
            o_entry.kind = lmbb_pkg::KIND_SKIP;
        end
    end

endmodule

// ===== hdl/lmbb_queue.sv =====
// ----------------------------------------------------------------------------
// lmbb_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module lmbb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lmbb_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output lmbb_pkg::t_entry o_head,
    output logic             o_head_valid
);

    localparam int QD = lmbb_pkg::QDEPTH;
    localparam int PW = (lmbb_pkg::QPTR_W > 0) ? lmbb_pkg::QPTR_W : 1;

    lmbb_pkg::t_entry r_buf [QD];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count,  n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QD - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = r_count == (PW+1)'(QD);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/lmbb_back.sv =====
// ----------------------------------------------------------------------------
// lmbb_back
// Executes queued commands: applies mode changes and steps each led on a tick.
// ----------------------------------------------------------------------------
module lmbb_back #(
    parameter int NUM_LEDS = lmbb_pkg::NUM_LEDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lmbb_pkg::t_entry              i_head,
    input  logic                          i_head_valid,
    output logic                          o_pop,
    input  lmbb_pkg::t_cfg                i_cfg,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lmbb_pkg::LAMP_W-1:0]   o_lamp_bits,
    output logic [lmbb_pkg::DUTY_W-1:0]   o_breath_duty,
    output logic                          o_accepted
);

    localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int MW    = lmbb_pkg::MODE_W;
    localparam int PRW   = lmbb_pkg::PERIOD_W;
    localparam int DW    = lmbb_pkg::DUTY_W;
    localparam int LW    = lmbb_pkg::LAMP_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TICK = 3'b010,
        ST_POST = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    logic [LED_W-1:0] r_cnt, n_cnt;

    // per-led state
    logic [MW-1:0]  r_mode   [NUM_LEDS];
    logic [MW-1:0]  r_saved  [NUM_LEDS];
    logic           r_lit    [NUM_LEDS];
    logic [1:0]     r_fl     [NUM_LEDS];
    logic [PRW-1:0] r_timer  [NUM_LEDS];

    logic [DW-1:0] r_duty, n_duty;
    logic          r_rising, n_rising;
    logic [LW-1:0] r_lamp, n_lamp;
    logic          r_acc, n_acc;
    logic          r_out_valid, n_out_valid;
    logic [LW-1:0] r_o_lamp;
    logic [DW-1:0] r_o_duty;
    logic          r_o_acc;

    logic [LED_W-1:0] sel;
    logic             do_set, do_tick, wr_en, load;
    logic [MW-1:0]    rd_mode, rd_saved;
    logic             rd_lit;
    logic [1:0]       rd_fl;
    logic [PRW-1:0]   rd_timer;

    logic [MW-1:0]  t_mode_v, tgt;
    logic           t_lit;
    logic [1:0]     t_fl;
    logic [PRW-1:0] t_timer;
    logic [PRW:0]   nxt;
    logic           want_apply, applied, lamp_on;

    logic [MW-1:0]  w_mode, w_saved;
    logic           w_lit;
    logic [1:0]     w_fl;
    logic [PRW-1:0] w_timer;

    logic [DW:0]   up_sum;
    logic [DW-1:0] up_duty;

    function automatic logic [PRW-1:0] period_of(input logic [MW-1:0] m,
                                                input lmbb_pkg::t_cfg c);
        if (m == lmbb_pkg::MODE_FAST || m == lmbb_pkg::MODE_TWICE) begin
            period_of = c.fast;
        end else if (m == lmbb_pkg::MODE_MEDIUM) begin
            period_of = c.mid;
        end else begin
            period_of = c.slow;
        end
    endfunction

    assign do_set  = (r_state == ST_IDLE) && i_head_valid
                     && (i_head.kind == lmbb_pkg::KIND_SET);
    assign do_tick = r_state == ST_TICK;
    assign wr_en   = do_set || do_tick;
    assign sel     = do_set ? LED_W'(i_head.idx) : r_cnt;

    assign rd_mode  = r_mode[sel];
    assign rd_saved = r_saved[sel];
    assign rd_lit   = r_lit[sel];
    assign rd_fl    = r_fl[sel];
    assign rd_timer = r_timer[sel];

    // one led step: flash timing, then an optional mode change
    always_comb begin
        t_mode_v   = rd_mode;
        t_lit      = rd_lit;
        t_fl       = rd_fl;
        t_timer    = rd_timer;
        nxt        = {1'b0, rd_timer} + (PRW+1)'(1);
        want_apply = do_set;
        tgt        = i_head.new_mode;
        if (do_tick) begin
            want_apply = 1'b0;
            tgt        = rd_saved;
            if (rd_mode inside {[lmbb_pkg::MODE_SLOW:lmbb_pkg::MODE_TWICE]}) begin
                if (nxt >= {1'b0, period_of(rd_mode, i_cfg)}) begin
                    t_timer = '0;
                    if (rd_lit) begin
                        t_lit = 1'b0;
                        if (rd_mode == lmbb_pkg::MODE_TWICE) begin
                            t_fl = rd_fl - 2'd1;
                            // second flash done: fall back to the saved mode
                            want_apply = t_fl == 2'd0;
                        end
                    end else begin
                        t_lit = 1'b1;
                    end
                end else begin
                    t_timer = nxt[PRW-1:0];
                end
            end
        end
        applied = want_apply && (t_mode_v != tgt)
                  && !(t_mode_v == lmbb_pkg::MODE_TWICE && t_fl != 2'd0);
        w_mode  = t_mode_v;
        w_saved = rd_saved;
        w_lit   = t_lit;
        w_fl    = t_fl;
        w_timer = t_timer;
        if (applied) begin
            w_saved = t_mode_v;
            w_mode  = tgt;
            w_lit   = 1'b0;
            w_fl    = (tgt == lmbb_pkg::MODE_TWICE) ? lmbb_pkg::TWICE_COUNT : 2'd0;
            w_timer = period_of(tgt, i_cfg);
        end
        case (rd_mode)
            lmbb_pkg::MODE_ON, lmbb_pkg::MODE_BREATH: lamp_on = 1'b1;
            lmbb_pkg::MODE_SLOW, lmbb_pkg::MODE_MEDIUM,
            lmbb_pkg::MODE_FAST, lmbb_pkg::MODE_TWICE: lamp_on = w_lit;
            default: lamp_on = 1'b0;
        endcase
    end

    assign up_sum  = {1'b0, r_duty} + {1'b0, i_cfg.step};
    assign up_duty = up_sum[DW] ? {DW{1'b1}} : up_sum[DW-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_duty      = r_duty;
        n_rising    = r_rising;
        n_lamp      = r_lamp;
        o_pop       = 1'b0;
        load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    n_acc = do_set && applied;
                    n_cnt = '0;
                    n_state = (i_head.kind == lmbb_pkg::KIND_TICK) ? ST_TICK : ST_POST;
                end
            end
            ST_TICK: begin
                if (rd_mode == lmbb_pkg::MODE_BREATH) begin
                    if (r_rising) begin
                        n_duty = up_duty;
                        // duty above ceiling minus margin turns the triangle
                        if (({1'b0, up_duty} + lmbb_pkg::BREATH_MARGIN)
                                > {1'b0, i_cfg.max}) begin
                            n_rising = 1'b0;
                        end
                    end else if (r_duty <= i_cfg.step) begin
                        n_rising = 1'b1;
                    end else begin
                        n_duty = r_duty - i_cfg.step;
                    end
                end
                for (int b = 0; b < LW; b++) begin
                    if (32'(r_cnt) == b) begin
                        n_lamp[b] = lamp_on;
                    end
                end
                if (r_cnt == LED_W'(NUM_LEDS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_POST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_POST: begin
                if (!r_out_valid || !i_out_stall) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_duty      <= '0;
            r_rising    <= 1'b1;
            r_lamp      <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_mode[i]  <= lmbb_pkg::MODE_OFF;
                r_saved[i] <= lmbb_pkg::MODE_OFF;
                r_lit[i]   <= 1'b0;
                r_fl[i]    <= 2'd0;
                r_timer[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_duty      <= n_duty;
            r_rising    <= n_rising;
            r_lamp      <= n_lamp;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_mode[sel]  <= w_mode;
                r_saved[sel] <= w_saved;
                r_lit[sel]   <= w_lit;
                r_fl[sel]    <= w_fl;
                r_timer[sel] <= w_timer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_lamp <= r_lamp;
            r_o_duty <= r_duty;
            r_o_acc  <= r_acc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lamp_bits   = r_o_lamp;
    assign o_breath_duty = r_o_duty;
    assign o_accepted    = r_o_acc;

endmodule

// ===== hdl/led_mode_blink_breath_controller.sv =====
// ----------------------------------------------------------------------------
// led_mode_blink_breath_controller
// Multi-led controller with off, on, three flash rates, flash-twice and
// breathing modes sharing one triangle pwm duty.
// ----------------------------------------------------------------------------
// With the two-entry input queue empty and the execution unit idle, a set
// command passes through the idle and post states and a tick through the
// idle, tick and post states: the execution unit pulls a command from the
// queue in the idle state, steps one led per cycle through a single shared
// led update path on a tick, and loads the output register in the post state.
// A set or tick occupies the execution unit until the output register is
// loaded, longer while a finished result waits on the stalled output
// register. The input side keeps taking commands into the queue meanwhile;
// stall rises only when the queue is full. Configuration writes take effect
// on the next cycle.
module led_mode_blink_breath_controller #(
    parameter int NUM_LEDS = lmbb_pkg::NUM_LEDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [lmbb_pkg::IDX_W-1:0]        i_led_index,
    input  logic [lmbb_pkg::MODE_W-1:0]       i_new_mode,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lmbb_pkg::LAMP_W-1:0]       o_lamp_bits,
    output logic [lmbb_pkg::DUTY_W-1:0]       o_breath_duty,
    output logic                              o_accepted,
    input  logic                              i_cfg_we,
    input  logic [lmbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmbb_pkg::PERIOD_W-1:0]     i_cfg_wdata
);

    lmbb_pkg::t_cfg   r_cfg, n_cfg;
    lmbb_pkg::t_entry push_entry, head;
    logic             push, full, pop, head_valid;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                lmbb_pkg::CFG_FAST:   n_cfg.fast = i_cfg_wdata;
                lmbb_pkg::CFG_MEDIUM: n_cfg.mid  = i_cfg_wdata;
                lmbb_pkg::CFG_SLOW:   n_cfg.slow = i_cfg_wdata;
                lmbb_pkg::CFG_STEP:   n_cfg.step = i_cfg_wdata;
                lmbb_pkg::CFG_MAX:    n_cfg.max  = i_cfg_wdata;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast <= lmbb_pkg::FAST_RST;
            r_cfg.mid  <= lmbb_pkg::MEDIUM_RST;
            r_cfg.slow <= lmbb_pkg::SLOW_RST;
            r_cfg.step <= lmbb_pkg::STEP_RST;
            r_cfg.max  <= lmbb_pkg::MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lmbb_front #(
        .NUM_LEDS (NUM_LEDS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_led_index (i_led_index),
        .i_new_mode  (i_new_mode),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    lmbb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    lmbb_back #(
        .NUM_LEDS (NUM_LEDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lamp_bits   (o_lamp_bits),
        .o_breath_duty (o_breath_duty),
        .o_accepted    (o_accepted)
    );

endmodule

// ===== hdl/lmbb_checker.sv =====
// ----------------------------------------------------------------------------
// lmbb_checker
// Port-level checks of the LED mode controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_mode_blink_breath_controller_macros.svh"

module lmbb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [lmbb_pkg::LAMP_W-1:0]       o_lamp_bits,
    input logic [lmbb_pkg::DUTY_W-1:0]       o_breath_duty,
    input logic                              o_accepted
);

    // a stalled result stays offered
    `LMBB_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `LMBB_ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_lamp_bits) && $stable(o_breath_duty) && $stable(o_accepted), "result payload changed while stalled")

    // the output register is empty after reset
    `LMBB_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result offered right after reset")

    // the command queue is empty after reset
    `LMBB_ASSERT_ALWAYS(a_rst_stall, i_clk, !i_rst_n |=> !o_in_stall, "input stalled right after reset")

endmodule

bind led_mode_blink_breath_controller lmbb_checker u_lmbb_checker (.*);
